### sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and the CORDIC angle table of the quaternion to
// Euler angle unit.
// ----------------------------------------------------------------------------
package qte_pkg;

	// quaternion component width, Q1.14
	localparam int QW = 16;
	// rotation matrix term width, Q.28 with headroom for CORDIC gain
	localparam int VEC_W = 37;
	// saturated asin argument, -2^28 .. 2^28, signed
	localparam int T_W = 30;
	// radicand of the square root, 0 .. 2^56
	localparam int RAD_W = 57;
	// square root result, 0 .. 2^28
	localparam int ROOT_W = 29;
	// one root bit per stage
	localparam int SQRT_STAGES = ROOT_W;
	// angle accumulator width, Q.20
	localparam int ANG_W = 24;

	localparam int ROLL_W  = 16;
	localparam int PITCH_W = 15;

	localparam int PI_Q13      = 25736;
	localparam int HALF_PI_Q13 = 12868;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = ANG_W'(1647099);

	typedef enum logic {
		FRAME_ENU = 1'b0,
		FRAME_NUE = 1'b1
	} frame_t;

	// atan(2^-i) in Q.20, rounded
	function automatic logic signed [ANG_W-1:0] atan_q20(input int unsigned i);
		logic signed [ANG_W-1:0] a;
		case (i)
			0:       a = ANG_W'(823550);
			1:       a = ANG_W'(486170);
			2:       a = ANG_W'(256879);
			3:       a = ANG_W'(130396);
			4:       a = ANG_W'(65451);
			5:       a = ANG_W'(32757);
			6:       a = ANG_W'(16383);
			7:       a = ANG_W'(8192);
			8:       a = ANG_W'(4096);
			9:       a = ANG_W'(2048);
			10:      a = ANG_W'(1024);
			11:      a = ANG_W'(512);
			12:      a = ANG_W'(256);
			13:      a = ANG_W'(128);
			14:      a = ANG_W'(64);
			15:      a = ANG_W'(32);
			16:      a = ANG_W'(16);
			17:      a = ANG_W'(8);
			18:      a = ANG_W'(4);
			19:      a = ANG_W'(2);
			20:      a = ANG_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### sv/qte_if.sv
// ----------------------------------------------------------------------------
// qte_if
// Valid/ready channels: quaternion beats in, Euler angle beats out.
// ----------------------------------------------------------------------------
interface qte_quat_if import qte_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [QW-1:0] quat_x;
	logic signed [QW-1:0] quat_y;
	logic signed [QW-1:0] quat_z;
	logic signed [QW-1:0] quat_w;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qte_euler_if import qte_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [ROLL_W-1:0]  roll_angle;
	logic signed [PITCH_W-1:0] pitch_angle;
	logic signed [ROLL_W-1:0]  yaw_angle;

	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### sv/quaternion_to_euler_angles_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Unit quaternion (Q1.14) to roll, pitch and yaw (Q3.13 radians).
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion beat is taken every cycle while the output
// is not stalled. Each result beat passes the three product/term stages, the
// 29-stage square root of the asin path and the CORDIC stages. The whole
// pipeline holds when the output beat is not taken. cfg_wdata selects ENU
// Z-Y-X (0) or NUE Y-Z-X (1) extraction; the user must write it only while
// the pipeline is empty, and the block itself does not enforce this.
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	qte_quat_if.sink       quat,
	qte_euler_if.source    euler
);

	localparam int LAT = 3 + SQRT_STAGES + CORDIC_STEPS + 2;

	frame_t frame_q;
	logic   en;
	logic   v_s [LAT];

	// convention register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_q <= FRAME_ENU;
		else if (cfg_we)
			frame_q <= frame_t'(cfg_wdata);
	end

	// global advance
	assign en         = euler.ready | ~v_s[LAT-1];
	assign quat.ready = en;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= quat.valid;
			for (int k = 1; k < LAT; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	logic signed [VEC_W-1:0] roll_x, roll_y, yaw_x, yaw_y;
	logic signed [T_W-1:0]   pitch_t;
	logic        [RAD_W-1:0] rad;

	qte_terms u_terms (
		.clk     (clk),
		.en      (en),
		.frame   (frame_q),
		.qx      (quat.quat_x),
		.qy      (quat.quat_y),
		.qz      (quat.quat_z),
		.qw      (quat.quat_w),
		.roll_x  (roll_x),
		.roll_y  (roll_y),
		.yaw_x   (yaw_x),
		.yaw_y   (yaw_y),
		.pitch_t (pitch_t),
		.rad     (rad)
	);

	logic [ROOT_W-1:0] root;

	qte_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad),
		.root (root)
	);

	// align roll, yaw and asin argument with the square root
	logic signed [VEC_W-1:0] rx_s [SQRT_STAGES];
	logic signed [VEC_W-1:0] ry_s [SQRT_STAGES];
	logic signed [VEC_W-1:0] yx_s [SQRT_STAGES];
	logic signed [VEC_W-1:0] yy_s [SQRT_STAGES];
	logic signed [T_W-1:0]   t_s  [SQRT_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= roll_x;
			ry_s[0] <= roll_y;
			yx_s[0] <= yaw_x;
			yy_s[0] <= yaw_y;
			t_s[0]  <= pitch_t;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				rx_s[k] <= rx_s[k-1];
				ry_s[k] <= ry_s[k-1];
				yx_s[k] <= yx_s[k-1];
				yy_s[k] <= yy_s[k-1];
				t_s[k]  <= t_s[k-1];
			end
		end
	end

	logic signed [VEC_W-1:0] px, py;

	assign px = VEC_W'($signed({1'b0, root}));
	assign py = VEC_W'(t_s[SQRT_STAGES-1]);

	qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13), .OUT_W(ROLL_W)) u_roll (
		.clk   (clk),
		.en    (en),
		.vx    (rx_s[SQRT_STAGES-1]),
		.vy    (ry_s[SQRT_STAGES-1]),
		.angle (euler.roll_angle)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(HALF_PI_Q13), .OUT_W(PITCH_W)) u_pitch (
		.clk   (clk),
		.en    (en),
		.vx    (px),
		.vy    (py),
		.angle (euler.pitch_angle)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS), .LIM(PI_Q13), .OUT_W(ROLL_W)) u_yaw (
		.clk   (clk),
		.en    (en),
		.vx    (yx_s[SQRT_STAGES-1]),
		.vy    (yy_s[SQRT_STAGES-1]),
		.angle (euler.yaw_angle)
	);

	assign euler.valid = v_s[LAT-1];

endmodule

### sv/qte_terms.sv
// ----------------------------------------------------------------------------
// qte_terms
// Three stages: component products, rotation matrix terms per convention
// with asin argument clamp, and the square root radicand 1 - t^2.
// ----------------------------------------------------------------------------
module qte_terms import qte_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  frame_t                   frame,
	input  logic signed [QW-1:0]     qx,
	input  logic signed [QW-1:0]     qy,
	input  logic signed [QW-1:0]     qz,
	input  logic signed [QW-1:0]     qw,
	output logic signed [VEC_W-1:0]  roll_x,
	output logic signed [VEC_W-1:0]  roll_y,
	output logic signed [VEC_W-1:0]  yaw_x,
	output logic signed [VEC_W-1:0]  yaw_y,
	output logic signed [T_W-1:0]    pitch_t,
	output logic        [RAD_W-1:0]  rad
);

	localparam logic signed [VEC_W-1:0] ONE = VEC_W'(1) <<< 28;

	logic signed [2*QW-1:0] pxx_s1, pyy_s1, pzz_s1, pwx_s1, pyz_s1;
	logic signed [2*QW-1:0] pwy_s1, pzx_s1, pwz_s1, pxy_s1;

	// stage 1: products, exact in 32 bits
	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1 <= qx * qx;
			pyy_s1 <= qy * qy;
			pzz_s1 <= qz * qz;
			pwx_s1 <= qw * qx;
			pyz_s1 <= qy * qz;
			pwy_s1 <= qw * qy;
			pzx_s1 <= qz * qx;
			pwz_s1 <= qw * qz;
			pxy_s1 <= qx * qy;
		end
	end

	logic signed [VEC_W-1:0] exx, eyy, ezz, ewx, eyz, ewy, ezx, ewz, exy;
	logic signed [VEC_W-1:0] roll_x_c, roll_y_c, yaw_x_c, yaw_y_c, pitch_c;
	logic signed [VEC_W-1:0] pitch_sat;

	// matrix terms for the selected convention
	always_comb begin
		exx = VEC_W'(pxx_s1);
		eyy = VEC_W'(pyy_s1);
		ezz = VEC_W'(pzz_s1);
		ewx = VEC_W'(pwx_s1);
		eyz = VEC_W'(pyz_s1);
		ewy = VEC_W'(pwy_s1);
		ezx = VEC_W'(pzx_s1);
		ewz = VEC_W'(pwz_s1);
		exy = VEC_W'(pxy_s1);
		if (frame == FRAME_NUE) begin
			roll_y_c = (ewx - eyz) <<< 1;
			roll_x_c = ONE - ((exx + ezz) <<< 1);
			pitch_c  = (exy + ewz) <<< 1;
			yaw_y_c  = (ewy - ezx) <<< 1;
			yaw_x_c  = ONE - ((eyy + ezz) <<< 1);
		end else begin
			roll_y_c = (ewx + eyz) <<< 1;
			roll_x_c = ONE - ((exx + eyy) <<< 1);
			pitch_c  = (ewy - ezx) <<< 1;
			yaw_y_c  = (ewz + exy) <<< 1;
			yaw_x_c  = ONE - ((eyy + ezz) <<< 1);
		end
		// asin argument held to plus or minus one
		if (pitch_c > ONE)
			pitch_sat = ONE;
		else if (pitch_c < -ONE)
			pitch_sat = -ONE;
		else
			pitch_sat = pitch_c;
	end

	logic signed [VEC_W-1:0] roll_x_s2, roll_y_s2, yaw_x_s2, yaw_y_s2;
	logic signed [T_W-1:0]   t_s2;

	// stage 2: terms
	always_ff @(posedge clk) begin
		if (en) begin
			roll_x_s2 <= roll_x_c;
			roll_y_s2 <= roll_y_c;
			yaw_x_s2  <= yaw_x_c;
			yaw_y_s2  <= yaw_y_c;
			t_s2      <= T_W'(pitch_sat);
		end
	end

	logic [T_W-1:0]     tmag;
	logic [2*T_W-1:0]   tsq;
	logic [RAD_W-1:0]   rad_c;

	// 1 - t^2 in Q.56
	always_comb begin
		tmag  = t_s2[T_W-1] ? T_W'(-t_s2) : T_W'(t_s2);
		tsq   = (2*T_W)'(tmag) * (2*T_W)'(tmag);
		rad_c = RAD_W'((RAD_W'(1) << 56) - RAD_W'(tsq));
	end

	// stage 3: radicand
	always_ff @(posedge clk) begin
		if (en) begin
			roll_x  <= roll_x_s2;
			roll_y  <= roll_y_s2;
			yaw_x   <= yaw_x_s2;
			yaw_y   <= yaw_y_s2;
			pitch_t <= t_s2;
			rad     <= rad_c;
		end
	end

endmodule

### sv/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [RAD_W-1:0]   rad,
	output logic [ROOT_W-1:0]  root
);

	localparam int RW = RAD_W + 1;

	logic [RW-1:0] rem_s  [SQRT_STAGES];
	logic [RW-1:0] root_s [SQRT_STAGES];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		localparam logic [RW-1:0] BITC = RW'(1) << (2 * (SQRT_STAGES - 1 - j));
		logic [RW-1:0] rem_in, root_in, trial;

		// previous stage or the input radicand
		if (j == 0) begin : g_first
			assign rem_in  = RW'(rad);
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
		end
		assign trial = root_in + BITC;

		// restoring step
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_s[j]  <= rem_in - trial;
					root_s[j] <= (root_in >> 1) + BITC;
				end else begin
					rem_s[j]  <= rem_in;
					root_s[j] <= root_in >> 1;
				end
			end
		end
	end

	assign root = root_s[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

### sv/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC atan2: quadrant fold stage, one stage per iteration and a
// rounding and saturation stage.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = 16,
	parameter int LIM   = 25736,
	parameter int OUT_W = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [VEC_W-1:0]  vx,
	input  logic signed [VEC_W-1:0]  vy,
	output logic signed [OUT_W-1:0]  angle
);

	logic signed [VEC_W-1:0] x_s [STEPS+1];
	logic signed [VEC_W-1:0] y_s [STEPS+1];
	logic signed [ANG_W-1:0] z_s [STEPS+1];
	logic                    zero_s [STEPS+1];

	// fold left half plane by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vx == '0) && (vy == '0);
			if (vx < 0) begin
				if (vy >= 0) begin
					x_s[0] <= vy;
					y_s[0] <= -vx;
					z_s[0] <= HALF_PI_Q20;
				end else begin
					x_s[0] <= -vy;
					y_s[0] <= vx;
					z_s[0] <= -HALF_PI_Q20;
				end
			end else begin
				x_s[0] <= vx;
				y_s[0] <= vy;
				z_s[0] <= '0;
			end
		end
	end

	// micro-rotations
	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ANG_W-1:0] A = atan_q20(i);
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + A;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - A;
				end
			end
		end
	end

	logic signed [ANG_W:0] zr, zsh;
	logic signed [ANG_W:0] ang_c;

	// Q.20 to Q.13 with rounding, then limit
	always_comb begin
		zr  = (ANG_W+1)'(z_s[STEPS]) + (ANG_W+1)'(64);
		zsh = zr >>> 7;
		if (zero_s[STEPS])
			ang_c = '0;
		else if (zsh > (ANG_W+1)'(LIM))
			ang_c = (ANG_W+1)'(LIM);
		else if (zsh < -(ANG_W+1)'(LIM))
			ang_c = -(ANG_W+1)'(LIM);
		else
			ang_c = zsh;
	end

	always_ff @(posedge clk) begin
		if (en)
			angle <= OUT_W'(ang_c);
	end

endmodule

### verif/quaternion_to_euler_angles_unit_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit_tb
// Self-checking bench for the quaternion to Euler angle unit: quaternion
// beats go in under random gaps, angle beats are checked in order against a
// bit-exact fixed-point predictor, in both frame conventions.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit_tb;
	import qte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS      = 16;
	localparam int LATENCY    = 50;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic signed [QW-1:0] w;
	} quat_t;

	typedef struct packed {
		logic signed [ROLL_W-1:0]  roll;
		logic signed [PITCH_W-1:0] pitch;
		logic signed [ROLL_W-1:0]  yaw;
	} euler_t;

	// fixed-point atan2 by vectoring CORDIC, Q.28 vector, Q.20 angle rounded to Q.13
	function automatic longint vector_angle(longint yv, longint xv, longint lim);
		longint ang, dx, dy, t, r;
		logic signed [ANG_W-1:0] step;
		ang = 0;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			t = xv;
			if (yv >= 0) begin
				xv = yv; yv = -t; ang = 1647099;
			end else begin
				xv = -yv; yv = t; ang = -1647099;
			end
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			step = atan_q20(i);
			if (yv >= 0) begin
				xv += dx; yv -= dy; ang += step;
			end else begin
				xv -= dx; yv += dy; ang -= step;
			end
		end
		r = (ang + 64) >>> 7;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	// asin via atan2(t, sqrt(1 - t^2)), argument saturated to +-1
	function automatic longint arc_sine(longint t);
		longint unsigned rad, root, bitv, a;
		if (t > (64'sd1 << 28)) t = 64'sd1 << 28;
		if (t < -(64'sd1 << 28)) t = -(64'sd1 << 28);
		a = (t < 0) ? -t : t;
		rad = (64'd1 << 56) - a * a;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rad) bitv >>= 2;
		while (bitv != 0) begin
			if (rad >= root + bitv) begin
				rad -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return vector_angle(t, longint'(root), HALF_PI_Q13);
	endfunction

	function automatic euler_t quat_to_angles(quat_t q, frame_t fr);
		longint x, y, z, w, one;
		euler_t e;
		x = q.x; y = q.y; z = q.z; w = q.w;
		one = 64'sd1 << 28;
		if (fr == FRAME_NUE) begin
			e.yaw   = ROLL_W'(vector_angle(2*y*w - 2*x*z, one - 2*y*y - 2*z*z, PI_Q13));
			e.roll  = ROLL_W'(vector_angle(2*x*w - 2*y*z, one - 2*x*x - 2*z*z, PI_Q13));
			e.pitch = PITCH_W'(arc_sine(2*x*y + 2*z*w));
		end else begin
			e.roll  = ROLL_W'(vector_angle(2*(w*x + y*z), one - 2*(x*x + y*y), PI_Q13));
			e.pitch = PITCH_W'(arc_sine(2*(w*y - z*x)));
			e.yaw   = ROLL_W'(vector_angle(2*(w*z + x*y), one - 2*(y*y + z*z), PI_Q13));
		end
		return e;
	endfunction

	class angle_scoreboard;
		euler_t pending_angles[$];
		frame_t frame;
		int errors;

		function void note_quat(quat_t q);
			pending_angles.push_back(quat_to_angles(q, frame));
		endfunction

		function void check_angles(euler_t got);
			euler_t want;
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected beat roll=%0d pitch=%0d yaw=%0d",
					$time, got.roll, got.pitch, got.yaw);
				errors++;
				return;
			end
			want = pending_angles.pop_front();
			if (got.roll !== want.roll) begin
				$display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
				errors++;
			end
			if (got.pitch !== want.pitch) begin
				$display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
					got.pitch);
				errors++;
			end
			if (got.yaw !== want.yaw) begin
				$display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	bit   calm = 1'b0;
	int   idle_cycles = 0;
	angle_scoreboard board = new();

	qte_quat_if  quat();
	qte_euler_if euler();

	quaternion_to_euler_angles_unit #(.CORDIC_STEPS(STEPS)) dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.quat(quat.sink), .euler(euler.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		quat.valid = 1'b0;
		quat.quat_x = '0; quat.quat_y = '0; quat.quat_z = '0; quat.quat_w = '0;
		euler.ready = 1'b0;
	end

	// result side: random stalls, check on each accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (euler.valid && euler.ready)
				board.check_angles({euler.roll_angle, euler.pitch_angle, euler.yaw_angle});
			euler.ready <= calm || ($urandom_range(99) >= 9);
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((quat.valid && quat.ready) || (euler.valid && euler.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_quat(quat_t q);
		while (!calm && $urandom_range(99) < 9) begin
			quat.valid <= 1'b0;
			@(posedge clk);
		end
		quat.valid <= 1'b1;
		{quat.quat_x, quat.quat_y, quat.quat_z, quat.quat_w} <= q;
		do @(posedge clk); while (!quat.ready);
		board.note_quat(q);
	endtask

	task automatic set_frame(frame_t fr);
		quat.valid <= 1'b0;
		@(posedge clk);
		while (board.pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= fr;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.frame = fr;
	endtask

	function automatic logic signed [QW-1:0] rand_comp();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 5) return QW'($urandom);
		if (k < 12) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
		if (k < 16) return '0;
		return QW'($signed($urandom_range(32768)) - 16384);
	endfunction

	// roughly unit quaternion: build from a random direction and normalize
	function automatic quat_t rand_unit();
		real a, b, c, d, n;
		quat_t q;
		a = $signed($urandom_range(2000)) - 1000;
		b = $signed($urandom_range(2000)) - 1000;
		c = $signed($urandom_range(2000)) - 1000;
		d = $signed($urandom_range(2000)) - 1000;
		n = $sqrt(a*a + b*b + c*c + d*d);
		if (n == 0.0) return '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
		q.x = QW'($rtoi(a / n * 16384.0));
		q.y = QW'($rtoi(b / n * 16384.0));
		q.z = QW'($rtoi(c / n * 16384.0));
		q.w = QW'($rtoi(d / n * 16384.0));
		return q;
	endfunction

	task automatic directed_set();
		quat_t q;
		send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		send_quat('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		send_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
		send_quat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		send_quat('{16'sd0, 16'sd0, 16'sd0, -16'sd16384});
		// gimbal lock, asin argument near +-1 in one of the two conventions
		send_quat('{16'sd0, 16'sd11585, 16'sd0, 16'sd11585});
		send_quat('{16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
		send_quat('{16'sd0, -16'sd11585, 16'sd0, 16'sd11585});
		// zero quaternion: every angle vector lies on the positive x axis
		send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		// out of range, asin saturates for some of these
		send_quat('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
		send_quat('{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000});
		send_quat('{-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff});
		send_quat('{16'sh5555, -16'sh2aab, 16'sh5555, -16'sh2aab});
		q = '{-16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384};
		send_quat(q);
	endtask

	task automatic random_set(int n);
		quat_t q;
		for (int i = 0; i < n; i++) begin
			calm = (i >= n / 2) && (i < n / 2 + 60);
			if ($urandom_range(99) < 75)
				q = rand_unit();
			else
				q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
			send_quat(q);
		end
		calm = 1'b0;
	endtask

	initial begin
		board.frame = FRAME_ENU;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_set();
		random_set(350);
		set_frame(FRAME_NUE);
		directed_set();
		random_set(350);
		set_frame(FRAME_ENU);
		random_set(350);
		set_frame(FRAME_NUE);
		random_set(350);
		quat.valid <= 1'b0;
		while (board.pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
